### sv/point_cloud_normal_estimator_defines.svh
// Assertion macros shared by the normal estimator RTL.
`ifndef POINT_CLOUD_NORMAL_ESTIMATOR_DEFINES_SVH
`define POINT_CLOUD_NORMAL_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCNE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCNE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/pcne_pkg.sv
// Shared constants and types of the point cloud normal estimator.
`default_nettype none

package pcne_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int STORE_DEPTH = 2 * MAX_WIDTH + 2;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);

   localparam int POINT_W     = 32;
   localparam int DIFF_W      = POINT_W + 1;
   localparam int NORM_W      = 16;
   localparam int ENTRY_W     = 3 * POINT_W;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 13;
   localparam int WIDTH_FLD_W = 11;
   localparam int HEIGHT_FLD_W = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_W'(1);

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // Neighbourhood slots, in fetch order.
   localparam int NUM_SLOTS = 5;
   localparam int SLOT_C = 0;
   localparam int SLOT_L = 1;
   localparam int SLOT_R = 2;
   localparam int SLOT_A = 3;
   localparam int SLOT_B = 4;

   typedef logic signed [DIFF_W-1:0] diff_type;

   typedef struct packed {
      logic start;
   } math_ctl_type;

   typedef struct packed {
      logic                     done;
      logic signed [NORM_W-1:0] nx;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nz;
   } math_res_type;

endpackage

`default_nettype wire

### sv/pcne_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pcne_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

### sv/pcne_math.sv
// Unit normal from two difference vectors on one shared multiplier,
// a bit-serial square root and a bit-serial divider.
`default_nettype none

module pcne_math (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pcne_pkg::math_ctl_type ctl,
   input  wire pcne_pkg::diff_type     d [6],
   output pcne_pkg::math_res_type      res
);

   localparam logic [32:0] LIM30 = 33'd1 << 30;
   localparam logic [63:0] TH39  = 64'd1 << 39;
   localparam logic [63:0] TH31  = 64'd1 << 31;
   localparam logic [63:0] TH30  = 64'd1 << 30;
   localparam logic [63:0] TH22  = 64'd1 << 22;
   localparam logic [63:0] BIT62 = 64'd1 << 62;

   typedef enum logic [3:0] {
      M_IDLE, M_ABS, M_SCALE, M_CROSS, M_CABS, M_MAX, M_NORM,
      M_SQ, M_SQRT, M_DSET, M_DIV, M_DONE
   } mstate_type;

   mstate_type state_ff, state_in;

   logic [32:0]        dmag_ff [6];
   logic [32:0]        dmag_in [6];
   logic               dneg_ff [6];
   logic               dneg_in [6];
   logic signed [31:0] a_ff [6];
   logic signed [31:0] a_in [6];
   logic [2:0]         idx_ff, idx_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [32:0] mul_a, mul_b;
   logic signed [63:0] c_ff [3];
   logic signed [63:0] c_in [3];
   logic [63:0]        m_ff [3];
   logic [63:0]        m_in [3];
   logic               neg_ff [3];
   logic               neg_in [3];
   logic [63:0]        mx_ff, mx_in;
   logic [63:0]        v_ff, v_in;
   logic [63:0]        r_ff, r_in;
   logic [63:0]        bit_ff, bit_in;
   logic [46:0]        rem_ff, rem_in;
   logic [46:0]        dsh_ff, dsh_in;
   logic [14:0]        q_ff, q_in;
   logic [3:0]         k_ff, k_in;
   logic [1:0]         ci_ff, ci_in;
   logic signed [15:0] n_ff [3];
   logic signed [15:0] n_in [3];

   logic [1:0]  sh_e [6];
   logic [1:0]  s_max;
   logic [2:0]  kk;
   logic [1:0]  cc;
   logic [63:0] rb;
   logic        ge;
   logic [14:0] qn;
   logic [15:0] nmag;
   logic [31:0] q32 [6];

   // common right shift that brings every difference to 2^30 or less
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         sh_e[i] = {1'b0, (dmag_ff[i] > LIM30)} + {1'b0, ((dmag_ff[i] >> 1) > LIM30)};
      end
      s_max = 2'd0;
      for (int i = 0; i < 6; i++) begin
         if (sh_e[i] > s_max) begin
            s_max = sh_e[i];
         end
      end
      for (int i = 0; i < 6; i++) begin
         q32[i] = 32'(dmag_ff[i] >> s_max);
      end
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == M_CROSS) begin
         case (idx_ff)
            3'd0: begin mul_a = 33'(a_ff[1]); mul_b = 33'(a_ff[5]); end
            3'd1: begin mul_a = 33'(a_ff[2]); mul_b = 33'(a_ff[4]); end
            3'd2: begin mul_a = 33'(a_ff[2]); mul_b = 33'(a_ff[3]); end
            3'd3: begin mul_a = 33'(a_ff[0]); mul_b = 33'(a_ff[5]); end
            3'd4: begin mul_a = 33'(a_ff[0]); mul_b = 33'(a_ff[4]); end
            3'd5: begin mul_a = 33'(a_ff[1]); mul_b = 33'(a_ff[3]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == M_SQ && idx_ff < 3'd3) begin
         mul_a = {2'b00, m_ff[idx_ff[1:0]][30:0]};
         mul_b = {2'b00, m_ff[idx_ff[1:0]][30:0]};
      end
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      mx_in    = mx_ff;
      v_in     = v_ff;
      r_in     = r_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      k_in     = k_ff;
      ci_in    = ci_ff;
      for (int i = 0; i < 6; i++) begin
         dmag_in[i] = dmag_ff[i];
         dneg_in[i] = dneg_ff[i];
         a_in[i]    = a_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         c_in[i]   = c_ff[i];
         m_in[i]   = m_ff[i];
         neg_in[i] = neg_ff[i];
         n_in[i]   = n_ff[i];
      end
      kk   = idx_ff - 3'd1;
      cc   = kk[2:1];
      rb   = r_ff + bit_ff;
      ge   = (rem_ff >= dsh_ff);
      qn   = {q_ff[13:0], ge};
      nmag = {1'b0, qn};

      unique case (state_ff)
         M_IDLE: begin
            if (ctl.start) begin
               state_in = M_ABS;
            end
         end
         M_ABS: begin
            for (int i = 0; i < 6; i++) begin
               dneg_in[i] = d[i][32];
               dmag_in[i] = d[i][32] ? (~d[i] + 33'd1) : d[i];
            end
            state_in = M_SCALE;
         end
         M_SCALE: begin
            for (int i = 0; i < 6; i++) begin
               a_in[i] = dneg_ff[i] ? (~q32[i] + 32'd1) : q32[i];
            end
            idx_in   = 3'd0;
            state_in = M_CROSS;
         end
         M_CROSS: begin
            // issue one product per cycle, fold the previous one into c
            if (idx_ff != 3'd0) begin
               if (!kk[0]) begin
                  c_in[cc] = prod_ff[63:0];
               end else begin
                  c_in[cc] = c_ff[cc] - prod_ff[63:0];
               end
            end
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'd6) begin
               state_in = M_CABS;
            end
         end
         M_CABS: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = c_ff[i][63];
               m_in[i]   = c_ff[i][63] ? (~c_ff[i] + 64'd1) : c_ff[i];
            end
            state_in = M_MAX;
         end
         M_MAX: begin
            mx_in = (m_ff[0] > m_ff[1]) ? m_ff[0] : m_ff[1];
            if (m_ff[2] > mx_in) begin
               mx_in = m_ff[2];
            end
            state_in = M_NORM;
         end
         M_NORM: begin
            // walk the largest magnitude into [2^30, 2^31)
            if (mx_ff == 64'd0) begin
               for (int i = 0; i < 3; i++) begin
                  n_in[i] = '0;
               end
               state_in = M_DONE;
            end else if (mx_ff >= TH39) begin
               mx_in = mx_ff >> 8;
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] >> 8;
            end else if (mx_ff >= TH31) begin
               mx_in = mx_ff >> 1;
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] >> 1;
            end else if (mx_ff < TH22) begin
               mx_in = mx_ff << 8;
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] << 8;
            end else if (mx_ff < TH30) begin
               mx_in = mx_ff << 1;
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] << 1;
            end else begin
               idx_in   = 3'd0;
               v_in     = 64'd0;
               state_in = M_SQ;
            end
         end
         M_SQ: begin
            if (idx_ff != 3'd0) begin
               v_in = v_ff + prod_ff[63:0];
            end
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'd3) begin
               r_in     = 64'd0;
               bit_in   = BIT62;
               state_in = M_SQRT;
            end
         end
         M_SQRT: begin
            if (v_ff >= rb) begin
               v_in = v_ff - rb;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               ci_in    = 2'd0;
               state_in = M_DSET;
            end
         end
         M_DSET: begin
            // rounded quotient: (m * 2^14 + r/2) / r, below 2^15
            rem_in   = (47'(m_ff[ci_ff][30:0]) << 14) + 47'(r_ff[31:1]);
            dsh_in   = 47'(r_ff[31:0]) << 14;
            q_in     = '0;
            k_in     = 4'd0;
            state_in = M_DIV;
         end
         M_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            q_in   = qn;
            dsh_in = dsh_ff >> 1;
            k_in   = k_ff + 4'd1;
            if (k_ff == 4'd14) begin
               n_in[ci_ff] = neg_ff[ci_ff] ? (~nmag + 16'd1) : nmag;
               if (ci_ff == 2'd2) begin
                  state_in = M_DONE;
               end else begin
                  ci_in    = ci_ff + 2'd1;
                  state_in = M_DSET;
               end
            end
         end
         M_DONE: begin
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      prod_ff <= prod_in;
      mx_ff   <= mx_in;
      v_ff    <= v_in;
      r_ff    <= r_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      k_ff    <= k_in;
      ci_ff   <= ci_in;
      for (int i = 0; i < 6; i++) begin
         dmag_ff[i] <= dmag_in[i];
         dneg_ff[i] <= dneg_in[i];
         a_ff[i]    <= a_in[i];
      end
      for (int i = 0; i < 3; i++) begin
         c_ff[i]   <= c_in[i];
         m_ff[i]   <= m_in[i];
         neg_ff[i] <= neg_in[i];
         n_ff[i]   <= n_in[i];
      end
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign res = {(state_ff == M_DONE), n_ff[0], n_ff[1], n_ff[2]};

endmodule

`default_nettype wire

### sv/point_cloud_normal_estimator.sv
// Top level of the organized point cloud surface normal estimator.
//
//   port group | dir | carries
//   req_*      | in  | one point (x, y, z Q16.16) or a flush pad per transaction
//   rsp_*      | out | one Q1.14 unit normal with valid and frame-last flags
//   csr_*      | in  | register writes: index 0 frame width, index 1 frame height
//
// A transaction that yields no normal keeps the block idle; one with a
// zero-depth neighbourhood skips the math unit; a full normal waits on its
// 32-step square root, three 15-step divisions and 1 to 11 step scaling.
// The input is not ready while a transaction is in work. A finished normal
// waits in the output register while the next transaction is taken.
// Synchronous reset: width 640, height 480, frame position zero; no store clear.
`default_nettype none

`include "point_cloud_normal_estimator_defines.svh"

module point_cloud_normal_estimator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [pcne_pkg::POINT_W-1:0]  req_pt_x,
   input  wire logic signed [pcne_pkg::POINT_W-1:0]  req_pt_y,
   input  wire logic signed [pcne_pkg::POINT_W-1:0]  req_pt_z,
   input  wire logic                                 req_pad,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [pcne_pkg::NORM_W-1:0]        rsp_norm_x,
   output logic signed [pcne_pkg::NORM_W-1:0]        rsp_norm_y,
   output logic signed [pcne_pkg::NORM_W-1:0]        rsp_norm_z,
   output logic                                      rsp_normal_valid,
   output logic                                      rsp_frame_last,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [pcne_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pcne_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW = pcne_pkg::ADDR_W;
   localparam int CW = pcne_pkg::COL_W;
   localparam int RW = pcne_pkg::ROW_W;
   localparam int EW = pcne_pkg::ENTRY_W;
   localparam int PW = pcne_pkg::POINT_W;
   localparam int NS = pcne_pkg::NUM_SLOTS;
   localparam int WIDTH_FLD_LOCAL = pcne_pkg::WIDTH_FLD_W;

   typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EVAL, S_MATH, S_DELIVER} state_type;

   state_type state_ff, state_in;

   logic [AW-1:0] w_ff, w_in;
   logic [RW-1:0] h_ff, h_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] base_ff, base_in;
   logic [AW-1:0] off_ff [NS];
   logic [AW-1:0] off_in [NS];
   logic [EW-1:0] pt_ff [NS];
   logic [EW-1:0] pt_in [NS];
   logic [2:0]    rd_ff, rd_in;
   logic          last_ff, last_in;
   logic          ok_ff, ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic signed [pcne_pkg::NORM_W-1:0] nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic          nvalid_ff, nvalid_in, flast_ff, flast_in;

   logic          accept, keep, emit, out_free, nb_ok;
   logic [EW-1:0] wdata;
   logic [AW-1:0] ox, kc, off_sel;
   logic [RW-1:0] oy;
   logic [CW:0]   col_p1;
   logic [AW:0]   addr_sum;
   logic [AW-1:0] raddr;
   logic [EW-1:0] rdata;
   logic [WIDTH_FLD_LOCAL-1:0] wv;
   logic [pcne_pkg::HEIGHT_FLD_W-1:0] hv;

   pcne_pkg::math_ctl_type math_ctl;
   pcne_pkg::math_res_type math_res;
   pcne_pkg::diff_type     dvec [6];

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // entry stored for this transaction: pads and flush rows store a zero depth
   assign keep  = (row_ff < h_ff) && !req_pad;
   assign wdata = keep ? {req_pt_x, req_pt_y, req_pt_z} : '0;
   assign emit  = (row_ff >= RW'(2)) || ((row_ff == RW'(1)) && (col_ff != '0));
   assign ox    = (col_ff != '0) ? (AW'(col_ff) - AW'(1)) : (w_ff - AW'(1));
   assign oy    = row_ff - ((col_ff != '0) ? RW'(1) : RW'(2));
   assign kc    = w_ff + AW'(1);
   assign col_p1 = {1'b0, col_ff} + (CW+1)'(1);
   assign wv    = csr_wdata[WIDTH_FLD_LOCAL-1:0];
   assign hv    = csr_wdata[pcne_pkg::HEIGHT_FLD_W-1:0];

   // ring address of a neighbour, counted back from this transaction's entry
   assign off_sel  = (rd_ff < 3'(NS)) ? off_ff[rd_ff] : '0;
   assign addr_sum = {1'b0, base_ff} + {1'b0, AW'(pcne_pkg::STORE_DEPTH) - off_sel};
   assign raddr    = (addr_sum >= (AW+1)'(pcne_pkg::STORE_DEPTH)) ?
                     AW'(addr_sum - (AW+1)'(pcne_pkg::STORE_DEPTH)) : AW'(addr_sum);

   always_comb begin
      nb_ok = 1'b1;
      for (int i = 0; i < NS; i++) begin
         if (pt_ff[i][PW-1:0] == '0) begin
            nb_ok = 1'b0;
         end
      end
      for (int j = 0; j < 3; j++) begin
         dvec[j] = {pt_ff[pcne_pkg::SLOT_R][EW-1-PW*j], pt_ff[pcne_pkg::SLOT_R][EW-1-PW*j -: PW]}
                 - {pt_ff[pcne_pkg::SLOT_L][EW-1-PW*j], pt_ff[pcne_pkg::SLOT_L][EW-1-PW*j -: PW]};
         dvec[j+3] = {pt_ff[pcne_pkg::SLOT_B][EW-1-PW*j], pt_ff[pcne_pkg::SLOT_B][EW-1-PW*j -: PW]}
                   - {pt_ff[pcne_pkg::SLOT_A][EW-1-PW*j], pt_ff[pcne_pkg::SLOT_A][EW-1-PW*j -: PW]};
      end
   end

   assign math_ctl.start = (state_ff == S_EVAL) && nb_ok;

   pcne_ram #(
      .WIDTH (EW),
      .DEPTH (pcne_pkg::STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (accept),
      .waddr (wp_ff),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   pcne_math u_math (
      .clock (clock),
      .reset (reset),
      .ctl   (math_ctl),
      .d     (dvec),
      .res   (math_res)
   );

   always_comb begin
      state_in     = state_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      wp_in        = wp_ff;
      base_in      = base_ff;
      rd_in        = rd_ff;
      last_in      = last_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      nz_in        = nz_ff;
      nvalid_in    = nvalid_ff;
      flast_in     = flast_ff;
      for (int i = 0; i < NS; i++) begin
         off_in[i] = off_ff[i];
         pt_in[i]  = pt_ff[i];
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               base_in = wp_ff;
               wp_in   = (wp_ff == AW'(pcne_pkg::STORE_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
               off_in[pcne_pkg::SLOT_C] = kc;
               off_in[pcne_pkg::SLOT_L] = kc + AW'(ox != '0);
               off_in[pcne_pkg::SLOT_R] = kc - AW'((ox + AW'(1)) < w_ff);
               off_in[pcne_pkg::SLOT_A] = kc + ((oy != '0) ? w_ff : '0);
               off_in[pcne_pkg::SLOT_B] = kc - (((oy + RW'(1)) < h_ff) ? w_ff : '0);
               last_in = ((oy + RW'(1)) == h_ff) && ((ox + AW'(1)) == w_ff);
               rd_in   = 3'd0;
               // advance the frame position; flush ends after one item of the next row
               if (row_ff > h_ff) begin
                  row_in = '0;
                  col_in = '0;
               end else if (AW'(col_p1) >= w_ff) begin
                  col_in = '0;
                  row_in = row_ff + RW'(1);
               end else begin
                  col_in = col_p1[CW-1:0];
               end
               if (emit) begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            if (rd_ff != 3'd0) begin
               pt_in[rd_ff - 3'd1] = rdata;
            end
            rd_in = rd_ff + 3'd1;
            if (rd_ff == 3'(NS)) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            ok_in    = nb_ok;
            state_in = nb_ok ? S_MATH : S_DELIVER;
         end
         S_MATH: begin
            if (math_res.done) begin
               state_in = S_DELIVER;
            end
         end
         S_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               nx_in        = ok_ff ? math_res.nx : '0;
               ny_in        = ok_ff ? math_res.ny : '0;
               nz_in        = ok_ff ? math_res.nz : '0;
               nvalid_in    = ok_ff;
               flast_in     = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register write restarts the frame; stored entries stay
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pcne_pkg::CSR_FRAME_WIDTH: begin
               if (wv == '0) begin
                  w_in = AW'(1);
               end else if (wv > WIDTH_FLD_LOCAL'(pcne_pkg::MAX_WIDTH)) begin
                  w_in = AW'(pcne_pkg::MAX_WIDTH);
               end else begin
                  w_in = AW'(wv);
               end
               col_in = '0;
               row_in = '0;
            end
            pcne_pkg::CSR_FRAME_HEIGHT: begin
               if (hv == '0) begin
                  h_in = RW'(1);
               end else if (hv > pcne_pkg::HEIGHT_FLD_W'(pcne_pkg::MAX_HEIGHT)) begin
                  h_in = RW'(pcne_pkg::MAX_HEIGHT);
               end else begin
                  h_in = RW'(hv);
               end
               col_in = '0;
               row_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      last_ff   <= last_in;
      ok_ff     <= ok_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      nz_ff     <= nz_in;
      nvalid_ff <= nvalid_in;
      flast_ff  <= flast_in;
      for (int i = 0; i < NS; i++) begin
         off_ff[i] <= off_in[i];
         pt_ff[i]  <= pt_in[i];
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         w_ff         <= AW'(pcne_pkg::RESET_WIDTH);
         h_ff         <= RW'(pcne_pkg::RESET_HEIGHT);
         col_ff       <= '0;
         row_ff       <= '0;
         wp_ff        <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         h_ff         <= h_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         wp_ff        <= wp_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_norm_x       = nx_ff;
   assign rsp_norm_y       = ny_ff;
   assign rsp_norm_z       = nz_ff;
   assign rsp_normal_valid = nvalid_ff;
   assign rsp_frame_last   = flast_ff;

   `PCNE_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid && !rsp_normal_valid, rsp_norm_x == 16'sd0 && rsp_norm_y == 16'sd0 && rsp_norm_z == 16'sd0, "invalid normal has nonzero components")
   `PCNE_ASSERT_IMP(a_norm_range, clock, reset, rsp_valid, rsp_norm_x <= 16'sd16384 && rsp_norm_x >= -16'sd16384 && rsp_norm_y <= 16'sd16384 && rsp_norm_y >= -16'sd16384 && rsp_norm_z <= 16'sd16384 && rsp_norm_z >= -16'sd16384, "normal component out of unit range")
   `PCNE_ASSERT_IMP(a_done_in_math, clock, reset, math_res.done, state_ff == S_MATH, "math unit finished outside the math wait")
   `PCNE_ASSERT_NXT(a_eval_leaves, clock, reset, state_ff == S_EVAL, state_ff == S_MATH || state_ff == S_DELIVER, "evaluation did not hand off")

endmodule

`default_nettype wire
